// ===== sv/tse_pkg.sv =====
package tse_pkg;

	localparam int MAX_TERMS_DEF = 11;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ROM_SIZE = 11;
	localparam int EPS_W = 16;
	localparam int CNT_W = 4;
	localparam int COEF_W = 32;
	localparam int COEF_FRAC = 31;
	localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

	// Running stop state of one request as it moves down the term stages.
	typedef struct packed {
		logic prev_big;
		logic cur_big;
		logic [CNT_W-1:0] count;
	} tse_ctl_t;

	// Series coefficients 2^2n (2^2n - 1) |B_2n| / (2n)!, Q1.31, truncated.
	function automatic logic [COEF_W-1:0] tse_coef(input int idx);
		logic [COEF_W-1:0] c;
		case (idx)
			0: c = 32'd2147483648;
			1: c = 32'd715827882;
			2: c = 32'd286331153;
			3: c = 32'd115895942;
			4: c = 32'd46964369;
			5: c = 32'd19033653;
			6: c = 32'd7714036;
			7: c = 32'd3126380;
			8: c = 32'd1267074;
			9: c = 32'd513525;
			10: c = 32'd208124;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/tse_term.sv =====
module tse_term #(
	parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF,
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [tse_pkg::EPS_W-1:0] eps,
	input  logic up_valid,
	output logic up_ready,
	input  logic [FRAC_BITS:0] up_x2,
	input  logic [FRAC_BITS:0] up_pw,
	input  logic [FRAC_BITS+3:0] up_acc,
	input  tse_pkg::tse_ctl_t up_ctl,
	output logic dn_valid,
	input  logic dn_ready,
	output logic [FRAC_BITS:0] dn_x2,
	output logic [FRAC_BITS:0] dn_pw,
	output logic [FRAC_BITS+3:0] dn_acc,
	output tse_pkg::tse_ctl_t dn_ctl
);
	import tse_pkg::*;

	localparam int PW = FRAC_BITS + 1;
	localparam int AW = FRAC_BITS + 4;
	localparam int TW = PW + 1;
	localparam int CMPW = (TW > EPS_W) ? TW : EPS_W;
	localparam logic [COEF_W-1:0] COEF = tse_coef(IDX);
	localparam logic [PW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic valid_s1;
	logic [PW-1:0] x2_s1;
	logic [PW-1:0] pw_s1;
	logic [AW-1:0] acc_s1;
	tse_ctl_t ctl_s1;

	logic en;
	logic active;
	logic [COEF_W+PW-1:0] term_prod;
	logic [TW-1:0] term;
	logic [2*PW-1:0] pw_prod;
	logic [PW-1:0] pw_next;
	logic [AW-1:0] acc_next;
	tse_ctl_t ctl_next;

	assign en = !valid_s1 || dn_ready;
	assign up_ready = en;

	assign term_prod = COEF * up_pw;
	assign term = term_prod[COEF_W+PW-1:COEF_FRAC];

	// Next odd power: a factor equal to one passes the other factor through.
	assign pw_prod = up_pw * up_x2;
	always_comb begin
		if (up_pw >= ONE) begin
			pw_next = up_x2;
		end else if (up_x2 >= ONE) begin
			pw_next = up_pw;
		end else begin
			pw_next = PW'(pw_prod[2*FRAC_BITS-1:FRAC_BITS]);
		end
	end

	// The series stops once two terms in a row are at or below epsilon.
	assign active = up_ctl.cur_big || up_ctl.prev_big;

	always_comb begin
		if (active) begin
			acc_next = up_acc + AW'(term);
			ctl_next.prev_big = up_ctl.cur_big;
			ctl_next.cur_big = CMPW'(term) > CMPW'(eps);
			ctl_next.count = CNT_W'(up_ctl.count + 4'd1);
		end else begin
			acc_next = up_acc;
			ctl_next = up_ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s1 <= up_x2;
			pw_s1 <= pw_next;
			acc_s1 <= acc_next;
			ctl_s1 <= ctl_next;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_x2 = x2_s1;
	assign dn_pw = pw_s1;
	assign dn_acc = acc_s1;
	assign dn_ctl = ctl_s1;

endmodule

// ===== sv/tangent_series_evaluator.sv =====
// A request passes the setup stage, every term stage and the output register in turn.
// Throughput: one request per cycle when not stalled; each term has a stage of its own
// with its own coefficient and power multipliers, and one setup stage forms x squared.
// A stalled output holds the pipeline back without loss; bubbles close up on their own.
// Reset clears all valid bits and loads epsilon with 66; no clearing pass is needed.
module tangent_series_evaluator #(
	parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF,
	parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tse_pkg::EPS_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [FRAC_BITS:0] angle,
	output logic out_valid,
	input  logic out_ready,
	output logic [FRAC_BITS:0] tangent,
	output logic [tse_pkg::CNT_W-1:0] terms_used
);
	import tse_pkg::*;

	localparam int PW = FRAC_BITS + 1;
	localparam int AW = FRAC_BITS + 4;
	localparam logic [PW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [PW-1:0] TOP = {PW{1'b1}};

	logic [EPS_W-1:0] eps_q;

	logic valid_s0;
	logic [PW-1:0] x2_s0;
	logic [PW-1:0] pw_s0;

	logic [PW-1:0] x_clamp;
	logic [2*PW-1:0] sq;
	logic [PW-1:0] x2;
	logic en0;

	logic vld [0:MAX_TERMS];
	logic rdy [0:MAX_TERMS];
	logic [PW-1:0] x2_c [0:MAX_TERMS];
	logic [PW-1:0] pw_c [0:MAX_TERMS];
	logic [AW-1:0] acc_c [0:MAX_TERMS];
	tse_ctl_t ctl_c [0:MAX_TERMS];

	logic out_valid_q;
	logic [PW-1:0] tangent_q;
	logic [CNT_W-1:0] terms_q;
	logic [PW-1:0] sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_valid) begin
			eps_q <= cfg_data;
		end
	end

	// Setup stage: clamp the angle to one and square it.
	assign x_clamp = (angle > ONE) ? ONE : angle;
	assign sq = x_clamp * x_clamp;
	assign x2 = (x_clamp >= ONE) ? x_clamp : PW'(sq[2*FRAC_BITS-1:FRAC_BITS]);

	assign en0 = !valid_s0 || rdy[0];
	assign in_ready = en0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en0) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en0) begin
			x2_s0 <= x2;
			pw_s0 <= x_clamp;
		end
	end

	assign vld[0] = valid_s0;
	assign x2_c[0] = x2_s0;
	assign pw_c[0] = pw_s0;
	assign acc_c[0] = '0;
	assign ctl_c[0] = '{prev_big: 1'b1, cur_big: 1'b1, count: '0};

	for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
		tse_term #(
			.FRAC_BITS(FRAC_BITS),
			.IDX(k)
		) u_term (
			.clk(clk),
			.arst_n(arst_n),
			.eps(eps_q),
			.up_valid(vld[k]),
			.up_ready(rdy[k]),
			.up_x2(x2_c[k]),
			.up_pw(pw_c[k]),
			.up_acc(acc_c[k]),
			.up_ctl(ctl_c[k]),
			.dn_valid(vld[k+1]),
			.dn_ready(rdy[k+1]),
			.dn_x2(x2_c[k+1]),
			.dn_pw(pw_c[k+1]),
			.dn_acc(acc_c[k+1]),
			.dn_ctl(ctl_c[k+1])
		);
	end

	// Output register with saturation of the sum.
	assign rdy[MAX_TERMS] = !out_valid_q || out_ready;
	assign sat = (acc_c[MAX_TERMS] > AW'(TOP)) ? TOP : acc_c[MAX_TERMS][PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy[MAX_TERMS]) begin
			out_valid_q <= vld[MAX_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[MAX_TERMS]) begin
			tangent_q <= sat;
			terms_q <= ctl_c[MAX_TERMS].count;
		end
	end

	assign out_valid = out_valid_q;
	assign tangent = tangent_q;
	assign terms_used = terms_q;

	// The first two terms are always summed, and never more than the stage count.
	a_terms_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (terms_used >= CNT_W'(2)) && (terms_used <= CNT_W'(MAX_TERMS)))
		else $error("terms_used outside the possible range");

	// With the output draining, the ready chain must reach back to the input.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled although the output is not stalled");

	// A result taken is replaced by the item behind it or by a bubble, never repeated.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !vld[MAX_TERMS]) |=> !out_valid)
		else $error("result repeated after it was taken");

endmodule
